>>> hw/rtl/fgbk_pkg.sv
// shared types and constants for the fixed-gain barometric tracker
`default_nettype none

package fgbk_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_PRESSURE     = 3'd0,
    CFG_GAIN_SPEED        = 3'd1,
    CFG_GAIN_ACCEL        = 3'd2,
    CFG_TIME_STEP         = 3'd3,
    CFG_HALF_STEP_SQUARED = 3'd4
  } cfg_idx_t;

  // reset values: 0.096 s and 0.004608 s^2 in unsigned 0.16
  localparam logic [15:0] TimeStepReset     = 16'd6291;
  localparam logic [15:0] HalfStepSqReset   = 16'd302;

  // configuration register file contents
  typedef struct packed {
    logic [31:0] gain_pressure;
    logic [31:0] gain_speed;
    logic [31:0] gain_accel;
    logic [15:0] time_step;
    logic [15:0] half_step_squared;
  } cfg_regs_t;

  // sequencer states
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_M0   = 10'b00_0000_0010,
    ST_M1   = 10'b00_0000_0100,
    ST_M2   = 10'b00_0000_1000,
    ST_M3   = 10'b00_0001_0000,
    ST_M4   = 10'b00_0010_0000,
    ST_M5   = 10'b00_0100_0000,
    ST_M6   = 10'b00_1000_0000,
    ST_M7   = 10'b01_0000_0000,
    ST_DONE = 10'b10_0000_0000
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/fgbk_cfg.sv
// configuration register file for the tracker gains and step constants
`default_nettype none

module fgbk_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [fgbk_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]                 cfg_data,
  output fgbk_pkg::cfg_regs_t              regs
);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_pressure     <= 32'd0;
      regs.gain_speed        <= 32'd0;
      regs.gain_accel        <= 32'd0;
      regs.time_step         <= fgbk_pkg::TimeStepReset;
      regs.half_step_squared <= fgbk_pkg::HalfStepSqReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fgbk_pkg::CFG_GAIN_PRESSURE:     regs.gain_pressure     <= cfg_data;
        fgbk_pkg::CFG_GAIN_SPEED:        regs.gain_speed        <= cfg_data;
        fgbk_pkg::CFG_GAIN_ACCEL:        regs.gain_accel        <= cfg_data;
        fgbk_pkg::CFG_TIME_STEP:         regs.time_step         <= cfg_data[15:0];
        fgbk_pkg::CFG_HALF_STEP_SQUARED: regs.half_step_squared <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fgbk_mul.sv
// shared 16x32 multiplier, low 32 bits of the product, registered
`default_nettype none

module fgbk_mul (
  input  wire logic        clk,
  input  wire logic [15:0] op_a,
  input  wire logic [31:0] op_b,
  output logic      [31:0] prod
);

  logic signed [47:0] full;

  // signed 16-bit times 32-bit pattern, wraps modulo 2^32
  always_comb begin
    full = 48'($signed(op_a)) * 48'($signed(op_b));
  end

  always_ff @(posedge clk) begin
    prod <= full[31:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/fixed_gain_baro_kalman_top.sv
// Fixed-gain alpha-beta-gamma pressure tracker on one shared multiplier.
// An init request loads the sample and goes straight to completion; an update
// request steps through M0 to M7, six passes through the one multiplier.
// A new request is taken only while idle, once the last result has been loaded.
// Reset (rst, synchronous): estimates cleared, gains zero, step 6291, half
// step squared 302, no result pending.
`default_nettype none

module fixed_gain_baro_kalman_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [fgbk_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]                  cfg_data,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         func,
  input  wire logic [16:0]                  pressure_sample,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [23:0]                  filtered_pressure,
  output logic signed [15:0]                pressure_rate,
  output logic signed [15:0]                pressure_accel
);

  fgbk_pkg::cfg_regs_t cfg;
  fgbk_pkg::state_t    state;

  logic [31:0] est_pressure;
  logic [31:0] est_speed;
  logic [31:0] est_accel;
  logic [31:0] sum;
  logic [15:0] sample_lo;
  logic [15:0] innov;
  logic [15:0] innov_next;
  logic [15:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic        in_take;
  logic        out_load;

  function automatic logic [31:0] asr8(input logic [31:0] v);
    asr8 = {{8{v[31]}}, v[31:8]};
  endfunction

  fgbk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  fgbk_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign in_stall = (state != fgbk_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state == fgbk_pkg::ST_DONE) && (!out_valid || !out_stall);

  // wrapped 16-bit innovation against the predicted estimate
  assign innov_next = sample_lo - est_pressure[23:8];

  // multiplier operand selection per step
  always_comb begin
    mul_a = est_speed[31:16];
    mul_b = {16'd0, cfg.time_step};
    unique case (state)
      fgbk_pkg::ST_M1: begin
        mul_a = est_accel[31:16];
        mul_b = {16'd0, cfg.half_step_squared};
      end
      fgbk_pkg::ST_M2: begin
        mul_a = est_accel[31:16];
        mul_b = {16'd0, cfg.time_step};
      end
      fgbk_pkg::ST_M4: begin
        mul_a = innov_next;
        mul_b = cfg.gain_pressure;
      end
      fgbk_pkg::ST_M5: begin
        mul_a = innov;
        mul_b = cfg.gain_speed;
      end
      fgbk_pkg::ST_M6: begin
        mul_a = innov;
        mul_b = cfg.gain_accel;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fgbk_pkg::ST_IDLE;
    end else begin
      unique case (state)
        fgbk_pkg::ST_IDLE: begin
          if (in_take) state <= func ? fgbk_pkg::ST_M0 : fgbk_pkg::ST_DONE;
        end
        fgbk_pkg::ST_M0: state <= fgbk_pkg::ST_M1;
        fgbk_pkg::ST_M1: state <= fgbk_pkg::ST_M2;
        fgbk_pkg::ST_M2: state <= fgbk_pkg::ST_M3;
        fgbk_pkg::ST_M3: state <= fgbk_pkg::ST_M4;
        fgbk_pkg::ST_M4: state <= fgbk_pkg::ST_M5;
        fgbk_pkg::ST_M5: state <= fgbk_pkg::ST_M6;
        fgbk_pkg::ST_M6: state <= fgbk_pkg::ST_M7;
        fgbk_pkg::ST_M7: state <= fgbk_pkg::ST_DONE;
        fgbk_pkg::ST_DONE: begin
          if (out_load) state <= fgbk_pkg::ST_IDLE;
        end
        default: state <= fgbk_pkg::ST_IDLE;
      endcase
    end
  end

  // estimate state: predict then correct, one product per step
  always_ff @(posedge clk) begin
    if (rst) begin
      est_pressure <= 32'd0;
      est_speed    <= 32'd0;
      est_accel    <= 32'd0;
    end else begin
      if (in_take && !func) begin
        est_pressure <= {7'd0, pressure_sample, 8'd0};
      end
      unique case (state)
        fgbk_pkg::ST_M3: begin
          est_pressure <= est_pressure + asr8(sum);
          est_speed    <= est_speed + prod;
        end
        fgbk_pkg::ST_M5: est_pressure <= est_pressure + asr8(prod);
        fgbk_pkg::ST_M6: est_speed    <= est_speed + prod;
        fgbk_pkg::ST_M7: est_accel    <= est_accel + prod;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_take) sample_lo <= pressure_sample[15:0];
    if (state == fgbk_pkg::ST_M1) sum <= prod;
    if (state == fgbk_pkg::ST_M2) sum <= sum + prod;
    if (state == fgbk_pkg::ST_M4) innov <= innov_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_pressure <= est_pressure[31:8];
      pressure_rate     <= $signed(est_speed[31:16]);
      pressure_accel    <= $signed(est_accel[31:16]);
    end
  end

`ifndef SYNTHESIS
  // an update request starts the multiply sequence
  a_update_start: assert property (@(posedge clk) disable iff (rst)
    (in_take && func) |=> (state == fgbk_pkg::ST_M0))
    else $error("update request did not start the sequence");

  // an init request loads a whole-pascal estimate
  a_init_load: assert property (@(posedge clk) disable iff (rst)
    (in_take && !func) |=> (est_pressure[7:0] == 8'd0 && state == fgbk_pkg::ST_DONE))
    else $error("init request loaded a wrong estimate");

  // a finished request lands in the result register and frees the block
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == fgbk_pkg::ST_IDLE))
    else $error("result not presented after completion");

  // the last correction step always hands over to completion
  a_seq_end: assert property (@(posedge clk) disable iff (rst)
    (state == fgbk_pkg::ST_M7) |=> (state == fgbk_pkg::ST_DONE))
    else $error("sequence did not reach completion");
`endif

endmodule

`default_nettype wire
